// ===== design/m6502x_pkg.sv =====
package m6502x_pkg;

   // Stack RAM geometry. The depth must be a power of two so that the
   // stack pointer folds onto the RAM by keeping its low bits.
   localparam int STACK_DEPTH = 256;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);

   // Register port geometry.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Register index, taken from the word-address bits of the byte address.
   localparam logic [CSR_AW-3:0] REG_BREAK_VECTOR = '0;

   // Operation codes.
   localparam logic [5:0] OP_NOP = 6'd0;
   localparam logic [5:0] OP_SEI = 6'd1;
   localparam logic [5:0] OP_SED = 6'd2;
   localparam logic [5:0] OP_SEC = 6'd3;
   localparam logic [5:0] OP_CLC = 6'd4;
   localparam logic [5:0] OP_CLD = 6'd5;
   localparam logic [5:0] OP_CLI = 6'd6;
   localparam logic [5:0] OP_CLV = 6'd7;
   localparam logic [5:0] OP_JMP = 6'd8;
   localparam logic [5:0] OP_LDA = 6'd9;
   localparam logic [5:0] OP_LDX = 6'd10;
   localparam logic [5:0] OP_LDY = 6'd11;
   localparam logic [5:0] OP_STA = 6'd12;
   localparam logic [5:0] OP_STY = 6'd13;
   localparam logic [5:0] OP_STX = 6'd14;
   localparam logic [5:0] OP_TAX = 6'd15;
   localparam logic [5:0] OP_TAY = 6'd16;
   localparam logic [5:0] OP_TSX = 6'd17;
   localparam logic [5:0] OP_TXA = 6'd18;
   localparam logic [5:0] OP_TXS = 6'd19;
   localparam logic [5:0] OP_TYA = 6'd20;
   localparam logic [5:0] OP_ROL = 6'd21;
   localparam logic [5:0] OP_ROR = 6'd22;
   localparam logic [5:0] OP_BCC = 6'd23;
   localparam logic [5:0] OP_BCS = 6'd24;
   localparam logic [5:0] OP_BEQ = 6'd25;
   localparam logic [5:0] OP_BMI = 6'd26;
   localparam logic [5:0] OP_BNE = 6'd27;
   localparam logic [5:0] OP_BPL = 6'd28;
   localparam logic [5:0] OP_BVC = 6'd29;
   localparam logic [5:0] OP_BVS = 6'd30;
   localparam logic [5:0] OP_PHA = 6'd31;
   localparam logic [5:0] OP_PHP = 6'd32;
   localparam logic [5:0] OP_PLA = 6'd33;
   localparam logic [5:0] OP_PLP = 6'd34;
   localparam logic [5:0] OP_JSR = 6'd35;
   localparam logic [5:0] OP_RTS = 6'd36;
   localparam logic [5:0] OP_BRK = 6'd37;
   localparam logic [5:0] OP_RTI = 6'd38;

   // Bit positions in P.
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] FLAG_B_MASK = 8'h10;
   localparam logic [7:0] SP_RESET    = 8'hFF;

   // Sequencer steps of the multi-cycle stack operations.
   localparam logic [1:0] STEP_0 = 2'd0;
   localparam logic [1:0] STEP_1 = 2'd1;
   localparam logic [1:0] STEP_2 = 2'd2;
   localparam logic [1:0] STEP_3 = 2'd3;

   // Cycle adjustments reported with each result.
   localparam logic signed [3:0] EXTRA_NONE  = 4'sd0;
   localparam logic signed [3:0] EXTRA_MINUS = -4'sd1;
   localparam logic signed [3:0] EXTRA_ONE   = 4'sd1;
   localparam logic signed [3:0] EXTRA_TWO   = 4'sd2;
   localparam logic signed [3:0] EXTRA_FOUR  = 4'sd4;
   localparam logic signed [3:0] EXTRA_FIVE  = 4'sd5;

   typedef struct packed {
      logic [5:0]  operation;
      logic [15:0] operand;
      logic        from_memory;
      logic [7:0]  memory_value;
   } req_type;

   typedef struct packed {
      logic [15:0]       program_counter;
      logic [7:0]        accumulator;
      logic [7:0]        index_x;
      logic [7:0]        index_y;
      logic [7:0]        stack_pointer;
      logic [7:0]        processor_flags;
      logic              write_enable;
      logic [15:0]       write_address;
      logic [7:0]        write_data;
      logic signed [3:0] extra_cycles;
   } rsp_type;

   // Replaces N and Z in a flag byte with those of a value.
   function automatic logic [7:0] set_nz(input logic [7:0] flags, input logic [7:0] value);
      logic [7:0] result;
      result         = flags;
      result[FLAG_Z] = (value == 8'd0);
      result[FLAG_N] = value[7];
      return result;
   endfunction

endpackage

// ===== design/m6502x_ram.sv =====
module m6502x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cpu6502_misc_instruction_exec.sv =====
// Results: an accepted instruction's result is registered into the result queue;
// PLA, PLP, JSR, RTS, BRK and RTI first walk through further sequencer steps.
// Throughput: one beat per cycle while the result queue has room; a stack operation
// holds the request side until its last byte has moved, one byte per cycle.
// Reset: synchronous; registers clear, SP goes to 0xFF, and a clearing pass
// zeroes every stack RAM entry while the request side is stalled.
module cpu6502_misc_instruction_exec (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  m6502x_pkg::req_type               req_payload,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output m6502x_pkg::rsp_type               rsp_payload,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [m6502x_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [m6502x_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [m6502x_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                              csr_pready
);

   // Architectural registers.
   logic [7:0]  a_ff, a_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [7:0]  sp_ff, sp_in;
   logic [7:0]  p_ff, p_in;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] break_vector_ff;

   // Stack sequencer. A multi-byte stack operation holds its code here and
   // walks through its steps; tmp keeps a byte between two steps (the low
   // byte of a return address going out, or a pulled PC low byte coming in).
   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic [5:0]  op_ff, op_in;
   logic [7:0]  tmp_ff, tmp_in;

   // Post-reset clearing pass over the stack RAM.
   logic                            clear_ff;
   logic [m6502x_pkg::STACK_AW-1:0] clr_idx_ff;

   // Stack RAM port signals.
   logic                            ram_we;
   logic [m6502x_pkg::STACK_AW-1:0] ram_waddr;
   logic [7:0]                      ram_wdata;
   logic                            ram_re;
   logic [m6502x_pkg::STACK_AW-1:0] ram_raddr;
   logic [7:0]                      ram_rdata;

   // Two-entry result queue; q0 is the head shown on the result port.
   m6502x_pkg::rsp_type q0_ff, q1_ff;
   logic [1:0]          count_ff;

   logic                accept;
   logic                pop;
   logic                done;
   m6502x_pkg::rsp_type res;

   logic [7:0]  m_val;
   logic [7:0]  rot;
   logic [7:0]  sp_plus;
   logic [7:0]  sp_minus;
   logic [15:0] br_off;
   logic [15:0] br_target;
   logic [15:0] ret_pc;
   logic        branch_taken;
   logic        csr_wr;

   // The request side is held during the clearing pass, while a stack
   // sequence runs, and when the result queue is full. All three terms are
   // registered, so the stall never depends on the result side combinationally.
   assign req_stall = clear_ff | busy_ff | (count_ff == 2'd2);
   assign accept    = req_valid & ~req_stall;

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = q0_ff;
   assign pop         = rsp_valid & ~rsp_stall;

   // Register port. Only break_vector exists; other addresses read as zero
   // and ignore writes.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[m6502x_pkg::CSR_AW-1:2] == m6502x_pkg::REG_BREAK_VECTOR)
                       ? {{(m6502x_pkg::CSR_DW-16){1'b0}}, break_vector_ff}
                       : '0;

   assign sp_plus  = sp_ff + 8'd1;
   assign sp_minus = sp_ff - 8'd1;

   // Operand byte: from memory or the low byte of the immediate.
   assign m_val = req_payload.from_memory ? req_payload.memory_value
                                          : req_payload.operand[7:0];

   // Branch target in the PC offset convention (target minus 2).
   assign br_off    = {{8{req_payload.operand[7]}}, req_payload.operand[7:0]};
   assign br_target = pc_ff + br_off - 16'd2;
   assign ret_pc    = pc_ff + 16'd2;

   always_comb begin
      unique case (req_payload.operation)
         m6502x_pkg::OP_BCC: branch_taken = ~p_ff[m6502x_pkg::FLAG_C];
         m6502x_pkg::OP_BCS: branch_taken =  p_ff[m6502x_pkg::FLAG_C];
         m6502x_pkg::OP_BEQ: branch_taken =  p_ff[m6502x_pkg::FLAG_Z];
         m6502x_pkg::OP_BMI: branch_taken =  p_ff[m6502x_pkg::FLAG_N];
         m6502x_pkg::OP_BNE: branch_taken = ~p_ff[m6502x_pkg::FLAG_Z];
         m6502x_pkg::OP_BPL: branch_taken = ~p_ff[m6502x_pkg::FLAG_N];
         m6502x_pkg::OP_BVC: branch_taken = ~p_ff[m6502x_pkg::FLAG_V];
         m6502x_pkg::OP_BVS: branch_taken =  p_ff[m6502x_pkg::FLAG_V];
         default:            branch_taken = 1'b0;
      endcase
   end

   // Main execute logic. A push writes the RAM at SP and decrements SP in the
   // same cycle. A pull increments SP and issues the read at the new SP; the
   // data comes back from the RAM's output register in the next step, so
   // every pulled byte costs one sequencer step. Writes and reads of the same
   // entry never fall in one cycle, and a read always lands in a later cycle
   // than the write it depends on, so no forwarding path is needed.
   always_comb begin
      a_in      = a_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      sp_in     = sp_ff;
      p_in      = p_ff;
      pc_in     = pc_ff;
      busy_in   = busy_ff;
      step_in   = step_ff;
      op_in     = op_ff;
      tmp_in    = tmp_ff;
      done      = 1'b0;
      rot       = 8'd0;
      ram_we    = 1'b0;
      ram_waddr = sp_ff[m6502x_pkg::STACK_AW-1:0];
      ram_wdata = 8'd0;
      ram_re    = 1'b0;
      ram_raddr = sp_plus[m6502x_pkg::STACK_AW-1:0];
      res       = '0;

      if (clear_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_idx_ff;
      end else if (busy_ff) begin
         unique case (op_ff)
            m6502x_pkg::OP_PLA: begin
               a_in             = ram_rdata;
               p_in             = m6502x_pkg::set_nz(p_ff, ram_rdata);
               res.extra_cycles = m6502x_pkg::EXTRA_TWO;
               busy_in          = 1'b0;
               done             = 1'b1;
            end
            m6502x_pkg::OP_PLP: begin
               p_in             = ram_rdata;
               res.extra_cycles = m6502x_pkg::EXTRA_TWO;
               busy_in          = 1'b0;
               done             = 1'b1;
            end
            m6502x_pkg::OP_JSR: begin
               // Second push: low byte of the return address.
               ram_we           = 1'b1;
               ram_wdata        = tmp_ff;
               sp_in            = sp_minus;
               res.extra_cycles = m6502x_pkg::EXTRA_TWO;
               busy_in          = 1'b0;
               done             = 1'b1;
            end
            m6502x_pkg::OP_RTS: begin
               if (step_ff == m6502x_pkg::STEP_1) begin
                  tmp_in  = ram_rdata;
                  ram_re  = 1'b1;
                  sp_in   = sp_plus;
                  step_in = m6502x_pkg::STEP_2;
               end else begin
                  pc_in            = {ram_rdata, tmp_ff};
                  res.extra_cycles = m6502x_pkg::EXTRA_FOUR;
                  busy_in          = 1'b0;
                  done             = 1'b1;
               end
            end
            m6502x_pkg::OP_BRK: begin
               ram_we = 1'b1;
               sp_in  = sp_minus;
               if (step_ff == m6502x_pkg::STEP_1) begin
                  ram_wdata = tmp_ff;
                  step_in   = m6502x_pkg::STEP_2;
               end else begin
                  // Last push: P with B set, which P then keeps.
                  ram_wdata        = p_ff | m6502x_pkg::FLAG_B_MASK;
                  p_in             = p_ff | m6502x_pkg::FLAG_B_MASK;
                  res.extra_cycles = m6502x_pkg::EXTRA_FIVE;
                  busy_in          = 1'b0;
                  done             = 1'b1;
               end
            end
            m6502x_pkg::OP_RTI: begin
               unique case (step_ff)
                  m6502x_pkg::STEP_1: begin
                     p_in    = ram_rdata;
                     ram_re  = 1'b1;
                     sp_in   = sp_plus;
                     step_in = m6502x_pkg::STEP_2;
                  end
                  m6502x_pkg::STEP_2: begin
                     tmp_in  = ram_rdata;
                     ram_re  = 1'b1;
                     sp_in   = sp_plus;
                     step_in = m6502x_pkg::STEP_3;
                  end
                  default: begin
                     pc_in            = {ram_rdata, tmp_ff};
                     res.extra_cycles = m6502x_pkg::EXTRA_FOUR;
                     busy_in          = 1'b0;
                     done             = 1'b1;
                  end
               endcase
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (accept) begin
         done = 1'b1;
         unique case (req_payload.operation)
            m6502x_pkg::OP_SEI: p_in[m6502x_pkg::FLAG_I] = 1'b1;
            m6502x_pkg::OP_SED: p_in[m6502x_pkg::FLAG_D] = 1'b1;
            m6502x_pkg::OP_SEC: p_in[m6502x_pkg::FLAG_C] = 1'b1;
            m6502x_pkg::OP_CLC: p_in[m6502x_pkg::FLAG_C] = 1'b0;
            m6502x_pkg::OP_CLD: p_in[m6502x_pkg::FLAG_D] = 1'b0;
            m6502x_pkg::OP_CLI: p_in[m6502x_pkg::FLAG_I] = 1'b0;
            m6502x_pkg::OP_CLV: p_in[m6502x_pkg::FLAG_V] = 1'b0;
            m6502x_pkg::OP_JMP: begin
               pc_in            = req_payload.operand - 16'd3;
               res.extra_cycles = m6502x_pkg::EXTRA_MINUS;
            end
            m6502x_pkg::OP_LDA: begin
               a_in = m_val;
               p_in = m6502x_pkg::set_nz(p_ff, m_val);
            end
            m6502x_pkg::OP_LDX: begin
               x_in = m_val;
               p_in = m6502x_pkg::set_nz(p_ff, m_val);
            end
            m6502x_pkg::OP_LDY: begin
               y_in = m_val;
               p_in = m6502x_pkg::set_nz(p_ff, m_val);
            end
            m6502x_pkg::OP_STA: begin
               res.write_enable  = 1'b1;
               res.write_address = req_payload.operand;
               res.write_data    = a_ff;
            end
            m6502x_pkg::OP_STY: begin
               res.write_enable  = 1'b1;
               res.write_address = req_payload.operand;
               res.write_data    = y_ff;
            end
            m6502x_pkg::OP_STX: begin
               res.write_enable  = 1'b1;
               res.write_address = req_payload.operand;
               res.write_data    = x_ff;
            end
            m6502x_pkg::OP_TAX: begin
               x_in = a_ff;
               p_in = m6502x_pkg::set_nz(p_ff, a_ff);
            end
            m6502x_pkg::OP_TAY: begin
               y_in = a_ff;
               p_in = m6502x_pkg::set_nz(p_ff, a_ff);
            end
            m6502x_pkg::OP_TSX: begin
               x_in = sp_ff;
               p_in = m6502x_pkg::set_nz(p_ff, sp_ff);
            end
            m6502x_pkg::OP_TXA: begin
               a_in = x_ff;
               p_in = m6502x_pkg::set_nz(p_ff, x_ff);
            end
            m6502x_pkg::OP_TXS: sp_in = x_ff;
            m6502x_pkg::OP_TYA: begin
               a_in = y_ff;
               p_in = m6502x_pkg::set_nz(p_ff, y_ff);
            end
            m6502x_pkg::OP_ROL, m6502x_pkg::OP_ROR: begin
               // Both rotates go through the carry; N and Z follow the result.
               if (req_payload.operation == m6502x_pkg::OP_ROL) begin
                  rot = {m_val[6:0], p_ff[m6502x_pkg::FLAG_C]};
               end else begin
                  rot = {p_ff[m6502x_pkg::FLAG_C], m_val[7:1]};
               end
               p_in = m6502x_pkg::set_nz(p_ff, rot);
               p_in[m6502x_pkg::FLAG_C] = (req_payload.operation == m6502x_pkg::OP_ROL)
                                          ? m_val[7] : m_val[0];
               if (req_payload.from_memory) begin
                  res.write_enable  = 1'b1;
                  res.write_address = req_payload.operand;
                  res.write_data    = rot;
                  res.extra_cycles  = m6502x_pkg::EXTRA_TWO;
               end else begin
                  a_in = rot;
               end
            end
            m6502x_pkg::OP_BCC, m6502x_pkg::OP_BCS, m6502x_pkg::OP_BEQ,
            m6502x_pkg::OP_BMI, m6502x_pkg::OP_BNE, m6502x_pkg::OP_BPL,
            m6502x_pkg::OP_BVC, m6502x_pkg::OP_BVS: begin
               if (branch_taken) begin
                  pc_in            = br_target;
                  res.extra_cycles = (br_target[15:8] != pc_ff[15:8])
                                     ? m6502x_pkg::EXTRA_TWO : m6502x_pkg::EXTRA_ONE;
               end
            end
            m6502x_pkg::OP_PHA: begin
               ram_we           = 1'b1;
               ram_wdata        = a_ff;
               sp_in            = sp_minus;
               res.extra_cycles = m6502x_pkg::EXTRA_ONE;
            end
            m6502x_pkg::OP_PHP: begin
               ram_we           = 1'b1;
               ram_wdata        = p_ff;
               sp_in            = sp_minus;
               res.extra_cycles = m6502x_pkg::EXTRA_ONE;
            end
            m6502x_pkg::OP_PLA, m6502x_pkg::OP_PLP,
            m6502x_pkg::OP_RTS, m6502x_pkg::OP_RTI: begin
               // First pull: the byte arrives in the next step.
               ram_re  = 1'b1;
               sp_in   = sp_plus;
               done    = 1'b0;
               busy_in = 1'b1;
               step_in = m6502x_pkg::STEP_1;
               op_in   = req_payload.operation;
            end
            m6502x_pkg::OP_JSR: begin
               // Push the return high byte now, the low byte next step.
               ram_we    = 1'b1;
               ram_wdata = ret_pc[15:8];
               sp_in     = sp_minus;
               tmp_in    = ret_pc[7:0];
               pc_in     = req_payload.operand - 16'd3;
               done      = 1'b0;
               busy_in   = 1'b1;
               step_in   = m6502x_pkg::STEP_1;
               op_in     = req_payload.operation;
            end
            m6502x_pkg::OP_BRK: begin
               // Push PC high now, PC low and P in the next two steps.
               ram_we    = 1'b1;
               ram_wdata = pc_ff[15:8];
               sp_in     = sp_minus;
               tmp_in    = pc_ff[7:0];
               pc_in     = break_vector_ff - 16'd1;
               done      = 1'b0;
               busy_in   = 1'b1;
               step_in   = m6502x_pkg::STEP_1;
               op_in     = req_payload.operation;
            end
            default: begin
               // NOP and all unassigned codes leave the state unchanged.
            end
         endcase
      end

      res.program_counter = pc_in;
      res.accumulator     = a_in;
      res.index_x         = x_in;
      res.index_y         = y_in;
      res.stack_pointer   = sp_in;
      res.processor_flags = p_in;
   end

   m6502x_ram #(
      .WIDTH (8),
      .DEPTH (m6502x_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff            <= 8'd0;
         x_ff            <= 8'd0;
         y_ff            <= 8'd0;
         sp_ff           <= m6502x_pkg::SP_RESET;
         p_ff            <= 8'd0;
         pc_ff           <= 16'd0;
         break_vector_ff <= 16'd0;
         busy_ff         <= 1'b0;
         step_ff         <= m6502x_pkg::STEP_0;
         op_ff           <= m6502x_pkg::OP_NOP;
         clear_ff        <= 1'b1;
         clr_idx_ff      <= '0;
         count_ff        <= 2'd0;
      end else begin
         a_ff    <= a_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         sp_ff   <= sp_in;
         p_ff    <= p_in;
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
         op_ff   <= op_in;

         if (csr_wr && (csr_paddr[m6502x_pkg::CSR_AW-1:2] == m6502x_pkg::REG_BREAK_VECTOR)) begin
            break_vector_ff <= csr_pwdata[15:0];
         end

         if (clear_ff) begin
            clr_idx_ff <= clr_idx_ff + m6502x_pkg::STACK_AW'(1);
            if (clr_idx_ff == m6502x_pkg::STACK_AW'(m6502x_pkg::STACK_DEPTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end

         if (done && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !done) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Payload registers: the stack byte buffer and the result queue.
   always_ff @(posedge clock) begin
      tmp_ff <= tmp_in;
      if (pop) begin
         if (done) begin
            if (count_ff == 2'd1) begin
               q0_ff <= res;
            end else begin
               q0_ff <= q1_ff;
               q1_ff <= res;
            end
         end else begin
            q0_ff <= q1_ff;
         end
      end else if (done) begin
         if (count_ff == 2'd0) begin
            q0_ff <= res;
         end else begin
            q1_ff <= res;
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is ended by the watchdog if this many cycles pass without a beat
   // on either channel or a register access. The longest quiet stretch in a
   // correct run is the stack RAM clearing pass after reset or the deliberate
   // receiver hold-off; this leaves ample margin.
   localparam int WATCHDOG_LIMIT = 3000;
   // Cycles allowed after the last result for the block to settle. The
   // slowest instruction to allow for is RTI.
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_OFF_LEN   = 300;

   logic                            clock = 1'b0;
   logic                            reset;

   logic                            req_valid;
   logic                            req_stall;
   m6502x_pkg::req_type             req_payload;

   logic                            rsp_valid;
   logic                            rsp_stall;
   m6502x_pkg::rsp_type             rsp_payload;

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [m6502x_pkg::CSR_AW-1:0]   csr_paddr;
   logic [m6502x_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [m6502x_pkg::CSR_DW-1:0]   csr_prdata;
   logic                            csr_pready;

   cpu6502_misc_instruction_exec dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predicted processor state. This is the testbench's own copy of the
   // registers, the page-one stack and the break vector; it advances once
   // for every request beat that the block accepts.
   // ------------------------------------------------------------------
   logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
   logic [15:0] cpu_pc;
   logic [7:0]  stack_mem [m6502x_pkg::STACK_DEPTH];
   logic [15:0] break_target;

   // Expected result beats, oldest first.
   m6502x_pkg::rsp_type expected_cpu_states [$];
   m6502x_pkg::rsp_type oldest_state;

   int          error_count = 0;
   int          quiet_cycles = 0;

   // Shared controls: idle_enable switches random gaps on both channels, and
   // hold_off_cycles makes the result side stall for a long counted stretch.
   bit          idle_enable = 1'b0;
   int          hold_off_cycles = 0;

   function automatic void mark_sign_zero(input logic [7:0] value);
      cpu_p[m6502x_pkg::FLAG_Z] = (value == 8'h00);
      cpu_p[m6502x_pkg::FLAG_N] = value[7];
   endfunction

   // A push writes at SP and then moves SP down; a pull moves SP up first.
   // SP wraps within eight bits in both directions, and the stack entry is
   // SP folded onto the stack depth.
   function automatic void push_stack(input logic [7:0] value);
      stack_mem[cpu_sp[m6502x_pkg::STACK_AW-1:0]] = value;
      cpu_sp = cpu_sp - 8'd1;
   endfunction

   function automatic logic [7:0] pull_stack();
      cpu_sp = cpu_sp + 8'd1;
      return stack_mem[cpu_sp[m6502x_pkg::STACK_AW-1:0]];
   endfunction

   // A taken branch lands on PC plus the signed offset minus two, and reports
   // EXTRA_ONE, or EXTRA_TWO when the landing page differs from the old one.
   function automatic logic signed [3:0] take_branch(input logic taken,
                                                     input logic [7:0] offset);
      logic [15:0]       target;
      logic signed [3:0] cost;
      if (!taken) return m6502x_pkg::EXTRA_NONE;
      target = cpu_pc + {{8{offset[7]}}, offset} - 16'd2;
      cost   = (target[15:8] != cpu_pc[15:8]) ? m6502x_pkg::EXTRA_TWO
                                              : m6502x_pkg::EXTRA_ONE;
      cpu_pc = target;
      return cost;
   endfunction

   // Carries out one instruction on the predicted state and returns the
   // result beat the block should produce for it.
   function automatic m6502x_pkg::rsp_type execute_instruction(
         input m6502x_pkg::req_type instr);
      m6502x_pkg::rsp_type outcome;
      logic [7:0]          source_byte, rotated, low_byte, high_byte, branch_offset;
      logic [15:0]         return_addr;
      outcome = '0;
      outcome.extra_cycles = m6502x_pkg::EXTRA_NONE;
      // Loads and rotates use the memory byte when one was read, else the
      // low byte of the operand as an immediate.
      source_byte   = instr.from_memory ? instr.memory_value : instr.operand[7:0];
      branch_offset = instr.operand[7:0];
      case (instr.operation)
         m6502x_pkg::OP_SEI: cpu_p[m6502x_pkg::FLAG_I] = 1'b1;
         m6502x_pkg::OP_SED: cpu_p[m6502x_pkg::FLAG_D] = 1'b1;
         m6502x_pkg::OP_SEC: cpu_p[m6502x_pkg::FLAG_C] = 1'b1;
         m6502x_pkg::OP_CLC: cpu_p[m6502x_pkg::FLAG_C] = 1'b0;
         m6502x_pkg::OP_CLD: cpu_p[m6502x_pkg::FLAG_D] = 1'b0;
         m6502x_pkg::OP_CLI: cpu_p[m6502x_pkg::FLAG_I] = 1'b0;
         m6502x_pkg::OP_CLV: cpu_p[m6502x_pkg::FLAG_V] = 1'b0;
         m6502x_pkg::OP_JMP: begin
            cpu_pc = instr.operand - 16'd3;
            outcome.extra_cycles = m6502x_pkg::EXTRA_MINUS;
         end
         m6502x_pkg::OP_LDA: begin cpu_a = source_byte; mark_sign_zero(cpu_a); end
         m6502x_pkg::OP_LDX: begin cpu_x = source_byte; mark_sign_zero(cpu_x); end
         m6502x_pkg::OP_LDY: begin cpu_y = source_byte; mark_sign_zero(cpu_y); end
         m6502x_pkg::OP_STA, m6502x_pkg::OP_STY, m6502x_pkg::OP_STX: begin
            outcome.write_enable  = 1'b1;
            outcome.write_address = instr.operand;
            outcome.write_data    = (instr.operation == m6502x_pkg::OP_STA) ? cpu_a :
                                    (instr.operation == m6502x_pkg::OP_STY) ? cpu_y : cpu_x;
         end
         m6502x_pkg::OP_TAX: begin cpu_x = cpu_a;  mark_sign_zero(cpu_x); end
         m6502x_pkg::OP_TAY: begin cpu_y = cpu_a;  mark_sign_zero(cpu_y); end
         m6502x_pkg::OP_TSX: begin cpu_x = cpu_sp; mark_sign_zero(cpu_x); end
         m6502x_pkg::OP_TXA: begin cpu_a = cpu_x;  mark_sign_zero(cpu_a); end
         m6502x_pkg::OP_TXS: cpu_sp = cpu_x;
         m6502x_pkg::OP_TYA: begin cpu_a = cpu_y;  mark_sign_zero(cpu_a); end
         m6502x_pkg::OP_ROL, m6502x_pkg::OP_ROR: begin
            // Both rotates go through the carry flag.
            if (instr.operation == m6502x_pkg::OP_ROL) begin
               rotated                   = {source_byte[6:0], cpu_p[m6502x_pkg::FLAG_C]};
               cpu_p[m6502x_pkg::FLAG_C] = source_byte[7];
            end else begin
               rotated                   = {cpu_p[m6502x_pkg::FLAG_C], source_byte[7:1]};
               cpu_p[m6502x_pkg::FLAG_C] = source_byte[0];
            end
            mark_sign_zero(rotated);
            if (instr.from_memory) begin
               outcome.write_enable  = 1'b1;
               outcome.write_address = instr.operand;
               outcome.write_data    = rotated;
               outcome.extra_cycles  = m6502x_pkg::EXTRA_TWO;
            end else begin
               cpu_a = rotated;
            end
         end
         m6502x_pkg::OP_BCC:
            outcome.extra_cycles = take_branch(!cpu_p[m6502x_pkg::FLAG_C], branch_offset);
         m6502x_pkg::OP_BCS:
            outcome.extra_cycles = take_branch(cpu_p[m6502x_pkg::FLAG_C], branch_offset);
         m6502x_pkg::OP_BEQ:
            outcome.extra_cycles = take_branch(cpu_p[m6502x_pkg::FLAG_Z], branch_offset);
         m6502x_pkg::OP_BMI:
            outcome.extra_cycles = take_branch(cpu_p[m6502x_pkg::FLAG_N], branch_offset);
         m6502x_pkg::OP_BNE:
            outcome.extra_cycles = take_branch(!cpu_p[m6502x_pkg::FLAG_Z], branch_offset);
         m6502x_pkg::OP_BPL:
            outcome.extra_cycles = take_branch(!cpu_p[m6502x_pkg::FLAG_N], branch_offset);
         m6502x_pkg::OP_BVC:
            outcome.extra_cycles = take_branch(!cpu_p[m6502x_pkg::FLAG_V], branch_offset);
         m6502x_pkg::OP_BVS:
            outcome.extra_cycles = take_branch(cpu_p[m6502x_pkg::FLAG_V], branch_offset);
         m6502x_pkg::OP_PHA: begin
            push_stack(cpu_a);
            outcome.extra_cycles = m6502x_pkg::EXTRA_ONE;
         end
         m6502x_pkg::OP_PHP: begin
            push_stack(cpu_p);
            outcome.extra_cycles = m6502x_pkg::EXTRA_ONE;
         end
         m6502x_pkg::OP_PLA: begin
            cpu_a = pull_stack();
            mark_sign_zero(cpu_a);
            outcome.extra_cycles = m6502x_pkg::EXTRA_TWO;
         end
         m6502x_pkg::OP_PLP: begin
            cpu_p = pull_stack();
            outcome.extra_cycles = m6502x_pkg::EXTRA_TWO;
         end
         m6502x_pkg::OP_JSR: begin
            return_addr = cpu_pc + 16'd2;
            push_stack(return_addr[15:8]);
            push_stack(return_addr[7:0]);
            cpu_pc = instr.operand - 16'd3;
            outcome.extra_cycles = m6502x_pkg::EXTRA_TWO;
         end
         m6502x_pkg::OP_RTS: begin
            low_byte  = pull_stack();
            high_byte = pull_stack();
            cpu_pc    = {high_byte, low_byte};
            outcome.extra_cycles = m6502x_pkg::EXTRA_FOUR;
         end
         m6502x_pkg::OP_BRK: begin
            push_stack(cpu_pc[15:8]);
            push_stack(cpu_pc[7:0]);
            push_stack(cpu_p | m6502x_pkg::FLAG_B_MASK);
            cpu_p[m6502x_pkg::FLAG_B] = 1'b1;
            cpu_pc = break_target - 16'd1;
            outcome.extra_cycles = m6502x_pkg::EXTRA_FIVE;
         end
         m6502x_pkg::OP_RTI: begin
            cpu_p     = pull_stack();
            low_byte  = pull_stack();
            high_byte = pull_stack();
            cpu_pc    = {high_byte, low_byte};
            outcome.extra_cycles = m6502x_pkg::EXTRA_FOUR;
         end
         // NOP and every selector above RTI leave the state alone.
         default: ;
      endcase
      outcome.program_counter = cpu_pc;
      outcome.accumulator     = cpu_a;
      outcome.index_x         = cpu_x;
      outcome.index_y         = cpu_y;
      outcome.stack_pointer   = cpu_sp;
      outcome.processor_flags = cpu_p;
      return outcome;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic m6502x_pkg::req_type make_instr(input logic [5:0] op,
                                                      input logic [15:0] operand,
                                                      input logic from_memory,
                                                      input logic [7:0] value);
      m6502x_pkg::req_type instr;
      instr.operation    = op;
      instr.operand      = operand;
      instr.from_memory  = from_memory;
      instr.memory_value = value;
      return instr;
   endfunction

   function automatic m6502x_pkg::req_type random_instruction(input logic [5:0] op);
      return make_instr(op, 16'($urandom), 1'($urandom_range(1)), 8'($urandom));
   endfunction

   // Mostly defined instructions, with a small share of unused selectors.
   function automatic logic [5:0] random_operation();
      if ($urandom_range(99) < 5) return 6'($urandom_range(63, m6502x_pkg::OP_RTI + 1));
      return 6'($urandom_range(m6502x_pkg::OP_RTI, m6502x_pkg::OP_NOP));
   endfunction

   // Offers one request beat and returns once the block has taken it. The
   // valid is changed only at falling edges, and once per edge, so a beat
   // that follows directly keeps valid high without a glitch.
   task automatic issue_instruction(input m6502x_pkg::req_type instr);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 17) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = instr;
      do @(posedge clock); while (req_stall);
      expected_cpu_states.push_back(execute_instruction(instr));
   endtask

   // Stops offering beats and waits for every outstanding result, then lets
   // the slowest instruction's cycles pass so the block is truly at rest.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_cpu_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic compare_field(input string field, input logic [15:0] seen,
                                input logic [15:0] wanted);
      if (seen !== wanted)
         report_mismatch($sformatf("%s is %h, expected %h", field, seen, wanted));
   endtask

   // Writes the break vector with a setup and an access cycle, then reads it
   // back. Only called with the block at rest.
   task automatic write_break_vector(input logic [15:0] value);
      logic [m6502x_pkg::CSR_DW-1:0] word;
      word = {{(m6502x_pkg::CSR_DW-16){1'b0}}, value};
      wait_until_idle();
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {m6502x_pkg::REG_BREAK_VECTOR, 2'b00};
      csr_pwdata  = word;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      break_target = value;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== word)
         report_mismatch($sformatf("break vector reads %h, expected %h", csr_prdata, word));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // A stream of instructions in which about a quarter of the draws are
   // well-formed groups: a subroutine call and return, an interrupt and its
   // return, and a flag byte loaded through the stack followed by a
   // conditional branch. The groups drive the stack and the V flag into
   // states that single random instructions seldom reach.
   task automatic run_random_program(input int item_budget);
      int sent, pick, filler;
      sent = 0;
      while (sent < item_budget) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            filler = $urandom_range(3);
            issue_instruction(random_instruction(m6502x_pkg::OP_JSR));
            repeat (filler) issue_instruction(random_instruction(random_operation()));
            issue_instruction(random_instruction(m6502x_pkg::OP_RTS));
            sent += filler + 2;
         end else if (pick < 18) begin
            filler = $urandom_range(3);
            issue_instruction(random_instruction(m6502x_pkg::OP_BRK));
            repeat (filler) issue_instruction(random_instruction(random_operation()));
            issue_instruction(random_instruction(m6502x_pkg::OP_RTI));
            sent += filler + 2;
         end else if (pick < 26) begin
            issue_instruction(random_instruction(m6502x_pkg::OP_LDA));
            issue_instruction(random_instruction(m6502x_pkg::OP_PHA));
            issue_instruction(random_instruction(m6502x_pkg::OP_PLP));
            issue_instruction(random_instruction(
               6'($urandom_range(m6502x_pkg::OP_BVS, m6502x_pkg::OP_BCC))));
            sent += 4;
         end else begin
            issue_instruction(random_instruction(random_operation()));
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Hand-picked instructions: the reset state, field extremes, rotates in
   // both forms through the carry, page-crossing branches both ways, PC
   // wrap, SP wrap on push and pull, call and return, flags through the
   // stack, an interrupt with a zero vector and its return, and an unused
   // selector.
   task automatic test_directed_cases();
      issue_instruction(make_instr(m6502x_pkg::OP_NOP, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_LDA, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_LDA, 16'hFFFF, 1'b1, 8'hFF));
      issue_instruction(make_instr(m6502x_pkg::OP_TAX, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_SEC, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_ROL, 16'h0080, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_ROR, 16'hFFFF, 1'b1, 8'h01));
      issue_instruction(make_instr(m6502x_pkg::OP_CLC, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_ROL, 16'h8000, 1'b1, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_STA, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_STX, 16'hFFFF, 1'b0, 8'hFF));
      issue_instruction(make_instr(m6502x_pkg::OP_STY, 16'h1234, 1'b1, 8'h5A));
      issue_instruction(make_instr(m6502x_pkg::OP_BEQ, 16'h0080, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_BNE, 16'h007F, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_JMP, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_BCC, 16'h007F, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_LDX, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_TXS, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_PHA, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_PLA, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_JSR, 16'h8000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_RTS, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_PHP, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_PLP, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_BRK, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(m6502x_pkg::OP_RTI, 16'h0000, 1'b0, 8'h00));
      issue_instruction(make_instr(6'h3F, 16'hFFFF, 1'b1, 8'hFF));
   endtask

   // Interrupts taken at both extremes of the break vector and at two
   // values between, each followed by its return.
   task automatic test_break_vector_settings();
      logic [15:0] vectors [4];
      vectors = '{16'h0000, 16'hFFFF, 16'h8000, 16'($urandom)};
      foreach (vectors[i]) begin
         write_break_vector(vectors[i]);
         issue_instruction(random_instruction(m6502x_pkg::OP_BRK));
         issue_instruction(random_instruction(random_operation()));
         issue_instruction(random_instruction(m6502x_pkg::OP_RTI));
      end
   endtask

   // The bulk of the run. The first phase has no gaps on either channel;
   // later phases idle at random and change the break vector between them.
   task automatic test_random_programs();
      idle_enable = 1'b0;
      run_random_program(200);
      idle_enable = 1'b1;
      run_random_program(200);
      write_break_vector(16'($urandom));
      run_random_program(200);
      write_break_vector(16'hFFFF);
      run_random_program(150);
   endtask

   // The result side holds off for a long stretch while requests keep
   // coming, so the block fills and stalls its request side. Afterwards
   // the request side pauses until every result is back, then resumes.
   task automatic test_backpressure();
      idle_enable     = 1'b1;
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (40) issue_instruction(random_instruction(random_operation()));
      wait_until_idle();
      repeat (20) issue_instruction(random_instruction(random_operation()));
   endtask

   // ------------------------------------------------------------------
   // Result side: stall driver, checker and watchdog.
   // ------------------------------------------------------------------

   // Stall changes at falling edges only. A requested hold-off is counted
   // down here, one cycle per edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall = idle_enable && ($urandom_range(99) < 17);
         end
      end
   end

   // Every accepted result beat is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cpu_states.size() == 0) begin
            report_mismatch("result beat arrived with nothing expected");
         end else begin
            oldest_state = expected_cpu_states.pop_front();
            compare_field("program_counter", rsp_payload.program_counter,
                          oldest_state.program_counter);
            compare_field("accumulator", 16'(rsp_payload.accumulator),
                          16'(oldest_state.accumulator));
            compare_field("index_x", 16'(rsp_payload.index_x), 16'(oldest_state.index_x));
            compare_field("index_y", 16'(rsp_payload.index_y), 16'(oldest_state.index_y));
            compare_field("stack_pointer", 16'(rsp_payload.stack_pointer),
                          16'(oldest_state.stack_pointer));
            compare_field("processor_flags", 16'(rsp_payload.processor_flags),
                          16'(oldest_state.processor_flags));
            compare_field("write_enable", 16'(rsp_payload.write_enable),
                          16'(oldest_state.write_enable));
            compare_field("write_address", rsp_payload.write_address,
                          oldest_state.write_address);
            compare_field("write_data", 16'(rsp_payload.write_data),
                          16'(oldest_state.write_data));
            compare_field("extra_cycles", 16'(4'(rsp_payload.extra_cycles)),
                          16'(4'(oldest_state.extra_cycles)));
         end
      end
   end

   // Ends a hung run: any beat on either channel or a register access
   // restarts the count.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // Predicted state after reset: registers clear, SP at the top of page
      // one, the stack RAM zeroed and the break vector zero.
      cpu_a        = 8'h00;
      cpu_x        = 8'h00;
      cpu_y        = 8'h00;
      cpu_sp       = m6502x_pkg::SP_RESET;
      cpu_p        = 8'h00;
      cpu_pc       = 16'h0000;
      break_target = 16'h0000;
      foreach (stack_mem[i]) stack_mem[i] = 8'h00;

      // Reset is released at a falling edge. The block then runs its RAM
      // clearing pass with the request side stalled, which the first beat
      // simply waits out.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_break_vector_settings();
      test_random_programs();
      test_backpressure();

      wait_until_idle();
      repeat (10) @(posedge clock);
      if (expected_cpu_states.size() != 0) report_mismatch("results still outstanding at end");
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
